// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock with an active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check: whenever pre holds, con must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, pre, con, msg) \
    `ASSERT_CLK(label, clk, rst_n, (pre) |-> (con), msg)

`endif

// ===== sv/chd_pkg.sv =====
`timescale 1ns / 1ps

package chd_pkg;

    localparam int CODE_W   = 32;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 32;

    localparam int DEF_SYMBOLS = 256;
    localparam int DEF_MAX_LEN = 32;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOAD_ERR = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    out_symbol;
        logic [CODE_W-1:0]   assigned_code;
        logic [LEN_W-1:0]    assigned_length;
    } t_result;

endpackage

// ===== sv/chd_if.sv =====
`timescale 1ns / 1ps

interface chd_in_if import chd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic              bit_req;

    modport source (output valid, output mode, output symbol, output code_length,
                    output bit_req, input ready);
    modport sink   (input valid, input mode, input symbol, input code_length,
                    input bit_req, output ready);
endinterface

interface chd_out_if import chd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    out_symbol;
    logic [CODE_W-1:0]   assigned_code;
    logic [LEN_W-1:0]    assigned_length;

    modport source (output valid, output status, output out_symbol,
                    output assigned_code, output assigned_length, input ready);
    modport sink   (input valid, input status, input out_symbol,
                    input assigned_code, input assigned_length, output ready);
endinterface

// ===== sv/chd_ram.sv =====
`timescale 1ns / 1ps

module chd_ram #(
    parameter int W = 8,
    parameter int D = 256,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/chd_out_buf.sv =====
`timescale 1ns / 1ps

module chd_out_buf import chd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_res,
    output logic      o_space,
    chd_out_if.source o_out
);

    logic    r_valid;
    t_result r_data;

    // A slot frees up in the same cycle that the sink takes the held result.
    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_space) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_space) begin
            r_data <= i_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_data.status;
    assign o_out.out_symbol      = r_data.out_symbol;
    assign o_out.assigned_code   = r_data.assigned_code;
    assign o_out.assigned_length = r_data.assigned_length;

endmodule

// ===== sv/canonical_huffman_decoder_unit.sv =====
`timescale 1ns / 1ps
// Canonical Huffman decoder with an incrementally loaded code table.
// Input channel i_in carries one request per item: clear, load of one
// (symbol, length) pair, or one compressed bit to decode. Output channel
// o_out returns exactly one result per request. i_cfg_we/i_cfg_wdata set
// the symbol limit; write it only while the block is idle.
// One request is in flight at a time. A load, or a decode bit that does not
// finish a code, passes through the lookup state before its result; a decoded
// symbol passes through the lookup and symbol states; a clear, an unused mode
// or an ignored bit goes straight to the done state.
// The next request is taken in the cycle the result appears. The steps are
// set by the registered read of the per-length table memory, followed for a
// match by the registered read of the symbol memory.
// A single output register decouples the sink: while it holds a result, the
// next one waits internally and no new request is taken until it moves on.
// Synchronous reset empties the table (per-length valid flags), the decoder
// state and the symbol limit; there is no clearing pass over the memories.
// A clear request does the same, but keeps the symbol limit.
`include "assert_macros.svh"

module canonical_huffman_decoder_unit import chd_pkg::*; #(
    parameter int SYMBOLS = DEF_SYMBOLS,
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    chd_in_if.sink           i_in,
    chd_out_if.source        o_out
);

    localparam int IW  = $clog2(SYMBOLS);
    localparam int CW  = $clog2(SYMBOLS + 1);
    localparam int LW  = $clog2(MAX_LEN);
    localparam int PLW = $clog2(MAX_LEN + 1);
    localparam int TW  = CODE_W + IW + CW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SYM  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state n_state;
    t_state r_state;

    logic [CFG_W-1:0]  r_limit;
    logic [MODE_W-1:0] r_mode;
    logic [SYM_W-1:0]  r_sym;
    logic [LEN_W-1:0]  r_len;
    logic              r_bit;
    logic              r_hit_valid;
    logic [MAX_LEN-1:0] r_len_valid;
    logic [CW-1:0]     r_entry_count;
    logic [CODE_W-1:0] r_prev_code;
    logic [PLW-1:0]    r_prev_len;
    logic [CODE_W-1:0] r_pcode;
    logic [PLW-1:0]    r_plen;
    logic [CODE_W-1:0] r_dec_count;
    t_result           r_res;
    t_result           n_res;

    logic              in_acc;
    logic              limit_hit;
    logic              out_space;
    logic              out_push;

    logic              tbl_we;
    logic [LW-1:0]     tbl_waddr;
    logic [TW-1:0]     tbl_wdata;
    logic [LW-1:0]     tbl_raddr;
    logic [TW-1:0]     tbl_rdata;

    logic              sym_we;
    logic [IW-1:0]     sym_raddr;
    logic [SYM_W-1:0]  sym_rdata;

    logic [CODE_W-1:0] rd_first;
    logic [IW-1:0]     rd_base;
    logic [CW-1:0]     rd_cnt;
    logic [CW-1:0]     cnt;

    logic [CODE_W:0]   pc1;
    logic [LEN_W-1:0]  grow;
    logic [CODE_W-1:0] new_code;
    logic              bad_len;
    logic              tbl_full;
    logic              len_fall;
    logic              code_ovf;
    logic              load_ok;
    logic [STATUS_W-1:0] load_status;

    logic [CODE_W-1:0] nc;
    logic [PLW-1:0]    nl;
    logic [CODE_W-1:0] off;
    logic              hit;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign limit_hit  = (r_limit != '0) && (r_dec_count >= r_limit);
    assign out_push   = (r_state == S_DONE);

    // The table is read at acceptance, so its data is ready in the lookup state.
    assign tbl_raddr = (i_in.mode == MODE_LOAD) ? LW'(i_in.code_length - 6'd1)
                                                : r_plen[LW-1:0];

    assign rd_first = tbl_rdata[TW-1 -: CODE_W];
    assign rd_base  = tbl_rdata[CW +: IW];
    assign rd_cnt   = tbl_rdata[CW-1:0];
    assign cnt      = r_hit_valid ? rd_cnt : '0;

    // Next canonical code. It fits its length exactly when the previous code
    // plus one still fits the previous length.
    assign pc1      = {1'b0, r_prev_code} + {{CODE_W{1'b0}}, 1'b1};
    assign grow     = r_len - LEN_W'(r_prev_len);
    assign new_code = (r_prev_len == '0) ? '0 : (pc1[CODE_W-1:0] << grow);
    assign bad_len  = (r_len == '0) || (r_len > LEN_W'(MAX_LEN));
    assign tbl_full = (r_entry_count >= CW'(SYMBOLS));
    assign len_fall = (r_prev_len != '0) && (r_len < LEN_W'(r_prev_len));
    assign code_ovf = (r_prev_len != '0) && ((pc1 >> r_prev_len) != '0);

    always_comb begin
        load_status = ST_OK;
        if (bad_len) begin
            load_status = ST_LOAD_ERR;
        end else if (tbl_full) begin
            load_status = ST_FULL;
        end else if (len_fall || code_ovf) begin
            load_status = ST_LOAD_ERR;
        end
    end
    assign load_ok = (load_status == ST_OK);

    assign tbl_we    = (r_state == S_LOOK) && (r_mode == MODE_LOAD) && load_ok;
    assign sym_we    = tbl_we;
    assign tbl_waddr = LW'(r_len - 6'd1);
    assign tbl_wdata = {(cnt == '0) ? new_code : rd_first,
                        (cnt == '0) ? r_entry_count[IW-1:0] : rd_base,
                        cnt + CW'(1)};

    assign nc        = {r_pcode[CODE_W-2:0], r_bit};
    assign nl        = r_plen + PLW'(1);
    assign off       = nc - rd_first;
    assign hit       = (cnt != '0) && (nc >= rd_first) && (off < CODE_W'(cnt));
    assign sym_raddr = rd_base + off[IW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_LOAD) begin
                        n_state = S_LOOK;
                    end else if (i_in.mode == MODE_DECODE && !limit_hit) begin
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOOK: begin
                if (r_mode == MODE_DECODE && hit) begin
                    n_state = S_SYM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SYM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_space) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res = r_res;
        if (in_acc) begin
            n_res = '0;
            if (i_in.mode == MODE_DECODE && limit_hit) begin
                n_res.status = ST_LIMIT;
            end
        end
        if (r_state == S_LOOK) begin
            n_res = '0;
            if (r_mode == MODE_LOAD) begin
                n_res.status = load_status;
                if (load_ok) begin
                    n_res.assigned_code   = new_code;
                    n_res.assigned_length = r_len;
                end
            end else if (!hit && nl >= PLW'(MAX_LEN)) begin
                n_res.status = ST_TOO_LONG;
            end
        end
        if (r_state == S_SYM) begin
            n_res.status     = ST_SYMBOL;
            n_res.out_symbol = sym_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit       <= '0;
            r_len_valid   <= '0;
            r_entry_count <= '0;
            r_prev_code   <= '0;
            r_prev_len    <= '0;
            r_pcode       <= '0;
            r_plen        <= '0;
            r_dec_count   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_acc && i_in.mode == MODE_CLEAR) begin
                r_len_valid   <= '0;
                r_entry_count <= '0;
                r_prev_code   <= '0;
                r_prev_len    <= '0;
                r_pcode       <= '0;
                r_plen        <= '0;
                r_dec_count   <= '0;
            end
            if (tbl_we) begin
                r_len_valid[tbl_waddr] <= 1'b1;
                r_entry_count          <= r_entry_count + CW'(1);
                r_prev_code            <= new_code;
                r_prev_len             <= PLW'(r_len);
            end
            if (r_state == S_LOOK && r_mode == MODE_DECODE) begin
                if (hit) begin
                    r_pcode     <= '0;
                    r_plen      <= '0;
                    r_dec_count <= r_dec_count + CODE_W'(1);
                end else if (nl >= PLW'(MAX_LEN)) begin
                    r_pcode <= '0;
                    r_plen  <= '0;
                end else begin
                    r_pcode <= nc;
                    r_plen  <= nl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode      <= i_in.mode;
            r_sym       <= i_in.symbol;
            r_len       <= i_in.code_length;
            r_bit       <= i_in.bit_req;
            r_hit_valid <= r_len_valid[tbl_raddr];
        end
        r_res <= n_res;
    end

    chd_ram #(
        .W (TW),
        .D (MAX_LEN)
    ) u_len_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    chd_ram #(
        .W (SYM_W),
        .D (SYMBOLS)
    ) u_sym_store (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (r_entry_count[IW-1:0]),
        .i_wdata (r_sym),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    chd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (r_res),
        .o_space (out_space),
        .o_out   (o_out)
    );

    `ASSERT_IMPLY(a_plen_bound, i_clk, i_rst_n, 1'b1, r_plen < PLW'(MAX_LEN), "partial length out of range")
    `ASSERT_IMPLY(a_tbl_we_load, i_clk, i_rst_n, tbl_we, (r_state == S_LOOK) && (r_mode == MODE_LOAD), "table write outside a load")
    `ASSERT_IMPLY(a_sym_read_written, i_clk, i_rst_n, (r_state == S_LOOK) && (n_state == S_SYM), CW'(sym_raddr) < r_entry_count, "symbol read beyond loaded entries")
    `ASSERT_IMPLY(a_limit_no_lookup, i_clk, i_rst_n, in_acc && (i_in.mode == MODE_DECODE) && limit_hit, n_state == S_DONE, "ignored bit reached the table lookup")

endmodule

// ===== sim/canonical_huffman_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module canonical_huffman_decoder_unit_tb import chd_pkg::*; ();

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  code_length;
        logic              bit_req;
    } huff_req_t;

    class huff_scoreboard;
        logic [CFG_W-1:0]  symbol_limit;
        logic [SYM_W-1:0]  sym_mem [DEF_SYMBOLS];
        logic [CODE_W-1:0] first_code [DEF_MAX_LEN];
        int unsigned       len_count [DEF_MAX_LEN];
        int unsigned       base_index [DEF_MAX_LEN];
        int unsigned       n_entries;
        int unsigned       last_len;
        logic [CODE_W-1:0] last_code;
        logic [CODE_W-1:0] partial_code;
        int unsigned       partial_len;
        logic [31:0]       n_decoded;
        t_result           pending [$];
        int                errors;
        int                work_items;

        function new();
            symbol_limit = '0;
            errors = 0;
            work_items = 0;
            clear_table();
        endfunction

        // A clear request empties everything except the symbol limit.
        function void clear_table();
            foreach (len_count[i]) len_count[i] = 0;
            n_entries = 0;
            last_len = 0;
            last_code = '0;
            partial_code = '0;
            partial_len = 0;
            n_decoded = '0;
        endfunction

        function t_result decode_step(huff_req_t r);
            t_result     res;
            logic [63:0] code;
            int unsigned len;
            int unsigned idx;
            res = '0;
            case (r.mode)
                MODE_CLEAR: clear_table();
                MODE_LOAD: begin
                    len = r.code_length;
                    if (len == 0 || len > DEF_MAX_LEN) begin
                        res.status = ST_LOAD_ERR;
                    end else if (n_entries >= DEF_SYMBOLS) begin
                        res.status = ST_FULL;
                    end else if (last_len != 0 && len < last_len) begin
                        res.status = ST_LOAD_ERR;
                    end else begin
                        code = (last_len == 0) ? 64'd0 :
                               (64'(last_code) + 64'd1) << (len - last_len);
                        if ((code >> len) != 0) begin
                            res.status = ST_LOAD_ERR;
                        end else begin
                            if (len_count[len-1] == 0) begin
                                first_code[len-1] = code[31:0];
                                base_index[len-1] = n_entries;
                            end
                            len_count[len-1]++;
                            sym_mem[n_entries] = r.symbol;
                            n_entries++;
                            last_code = code[31:0];
                            last_len = len;
                            res.status = ST_OK;
                            res.assigned_code = code[31:0];
                            res.assigned_length = LEN_W'(len);
                        end
                    end
                end
                MODE_DECODE: begin
                    if (symbol_limit != 0 && n_decoded >= symbol_limit) begin
                        res.status = ST_LIMIT;
                    end else begin
                        partial_code = {partial_code[CODE_W-2:0], r.bit_req};
                        partial_len++;
                        idx = partial_len - 1;
                        if (len_count[idx] != 0 && partial_code >= first_code[idx] &&
                            (partial_code - first_code[idx]) < len_count[idx]) begin
                            res.status = ST_SYMBOL;
                            res.out_symbol =
                                sym_mem[base_index[idx] + (partial_code - first_code[idx])];
                            partial_code = '0;
                            partial_len = 0;
                            n_decoded++;
                        end else if (partial_len >= DEF_MAX_LEN) begin
                            partial_code = '0;
                            partial_len = 0;
                            res.status = ST_TOO_LONG;
                        end else begin
                            res.status = ST_OK;
                        end
                    end
                end
                default: res.status = ST_OK;
            endcase
            return res;
        endfunction

        function void note_request(huff_req_t r);
            t_result exp_res;
            exp_res = decode_step(r);
            pending = {pending, exp_res};
            work_items++;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result exp_res;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
            end else begin
                exp_res = pending.pop_front();
                if (got.status !== exp_res.status)
                    report($sformatf("status got %0d exp %0d", got.status, exp_res.status));
                if (got.out_symbol !== exp_res.out_symbol)
                    report($sformatf("out_symbol got %0h exp %0h",
                                     got.out_symbol, exp_res.out_symbol));
                if (got.assigned_code !== exp_res.assigned_code)
                    report($sformatf("assigned_code got %0h exp %0h",
                                     got.assigned_code, exp_res.assigned_code));
                if (got.assigned_length !== exp_res.assigned_length)
                    report($sformatf("assigned_length got %0d exp %0d",
                                     got.assigned_length, exp_res.assigned_length));
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    bit               bursts_on;
    int               cycle_count;
    int               stall_left;

    logic [CODE_W-1:0] table_codes [$];
    int                table_lens [$];

    huff_scoreboard sb;

    chd_in_if  in_if ();
    chd_out_if out_if ();

    canonical_huffman_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result sink: stalls come in bursts while bursts are enabled.
    initial begin
        out_if.ready = 1'b1;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.status = out_if.status;
            got.out_symbol = out_if.out_symbol;
            got.assigned_code = out_if.assigned_code;
            got.assigned_length = out_if.assigned_length;
            sb.check_result(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(huff_req_t r);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.mode = r.mode;
        in_if.symbol = r.symbol;
        in_if.code_length = r.code_length;
        in_if.bit_req = r.bit_req;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_mode(logic [MODE_W-1:0] mode);
        huff_req_t r;
        r.mode = mode;
        r.symbol = SYM_W'($urandom);
        r.code_length = LEN_W'($urandom);
        r.bit_req = 1'($urandom);
        send_req(r);
    endtask

    task automatic load(logic [SYM_W-1:0] sym, int len);
        huff_req_t r;
        r.mode = MODE_LOAD;
        r.symbol = sym;
        r.code_length = LEN_W'(len);
        r.bit_req = 1'($urandom);
        send_req(r);
    endtask

    task automatic decode_bit(logic b);
        huff_req_t r;
        r.mode = MODE_DECODE;
        r.symbol = SYM_W'($urandom);
        r.code_length = LEN_W'($urandom);
        r.bit_req = b;
        send_req(r);
    endtask

    task automatic decode_code(logic [CODE_W-1:0] code, int len);
        for (int b = len - 1; b >= 0; b--) decode_bit(code[b]);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Waits until every result is taken, so that the block is idle, before
    // touching the limit.
    task automatic set_limit(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (8) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        sb.symbol_limit = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Loads a random canonical table and keeps its codes for well-formed
    // decode traffic. Stops early once the code space is used up.
    task automatic load_random_table();
        int          n;
        int          len;
        int          delta;
        int          pick;
        logic [63:0] code;
        table_codes.delete();
        table_lens.delete();
        n = $urandom_range(1, 24);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
        code = 64'd0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if (code == (64'd1 << len) - 64'd1) break;
                pick = $urandom_range(0, 9);
                if (pick < 6) delta = 0;
                else if (pick < 9) delta = $urandom_range(1, 2);
                else delta = $urandom_range(1, 31);
                if (len + delta > DEF_MAX_LEN) delta = DEF_MAX_LEN - len;
                code = (code + 64'd1) << delta;
                len = len + delta;
            end
            load(SYM_W'($urandom), len);
            table_codes = {table_codes, code[31:0]};
            table_lens = {table_lens, len};
        end
    endtask

    initial begin
        int pick;
        int k;
        sb = new();
        bursts_on = 1'b0;
        cycle_count = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.mode = MODE_CLEAR;
        in_if.symbol = '0;
        in_if.code_length = '0;
        in_if.bit_req = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_limit(32'hFFFF_FFFF);

        // Unused mode with all fields high, then a bit against an empty table.
        in_if.valid = 1'b1;
        send_req('{mode: MODE_UNUSED, symbol: 8'hFF, code_length: 6'h3F, bit_req: 1'b1});
        decode_bit(1'b0);
        send_mode(MODE_CLEAR);

        // Two one-bit codes fill the code space; anything more overflows.
        load(8'h01, 1);
        load(8'hFE, 1);
        load(8'h33, 1);
        load(8'h34, 5);
        decode_bit(1'b1);
        decode_bit(1'b0);

        send_mode(MODE_CLEAR);
        load(8'h10, 0);
        load(8'h11, 33);
        load(8'h12, 63);
        load(8'h00, 1);
        load(8'hA5, 3);
        load(8'h77, 2);
        load(8'h00, 3);
        load(8'hFF, 32);
        decode_code(32'd5, 3);
        decode_code(32'd4, 3);
        decode_bit(1'b0);
        decode_code(32'hC000_0000, 32);
        // All ones never matches here, so 32 bits end as a code too long.
        repeat (32) decode_bit(1'b1);

        set_limit(32'd2);
        send_mode(MODE_CLEAR);
        load(8'h3C, 1);
        decode_bit(1'b0);
        decode_bit(1'b0);
        decode_bit(1'b0);
        decode_bit(1'b1);

        // Fill every table entry with 8-bit codes, then try one more.
        set_limit(32'd0);
        bursts_on = 1'b1;
        send_mode(MODE_CLEAR);
        for (int i = 0; i < DEF_SYMBOLS; i++) load(SYM_W'($urandom), 8);
        load(8'h5A, 8);
        load(8'h5B, 33);
        repeat (3) decode_code(CODE_W'($urandom_range(0, 255)), 8);

        while (sb.work_items < 550) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) set_limit(32'd0);
            else if (pick < 17) set_limit(CFG_W'($urandom_range(1, 8)));
            else if (pick < 19) set_limit(32'hFFFF_FFFF);
            else set_limit(CFG_W'($urandom));
            bursts_on = (sb.work_items < 450) && ($urandom_range(0, 3) != 0);
            in_if.valid = 1'b1;
            send_mode(MODE_CLEAR);
            load_random_table();
            k = $urandom_range(20, 80);
            for (int i = 0; i < k && sb.work_items < 550; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pick = $urandom_range(0, table_codes.size() - 1);
                    decode_code(table_codes[pick], table_lens[pick]);
                end else if (pick < 91) begin
                    decode_bit(1'($urandom));
                end else if (pick < 96) begin
                    load(SYM_W'($urandom), $urandom_range(0, 63));
                end else if (pick < 98) begin
                    send_mode(MODE_UNUSED);
                end else begin
                    send_mode(MODE_CLEAR);
                end
            end
        end

        bursts_on = 1'b0;
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
